// ===== rtl/rbgs_pkg.sv =====
// rbgs_pkg: shared constants, codes and types of the red-black gauss-seidel solver
`timescale 1ns / 1ps
package rbgs_pkg;

   localparam int GRID_SIDE_DEF = 64;
   localparam int VALUE_BITS    = 32;
   localparam int CSR_BITS      = 60;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_RUN  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [2:0] CSR_WEIGHT_X  = 3'd0;
   localparam logic [2:0] CSR_WEIGHT_Y  = 3'd1;
   localparam logic [2:0] CSR_GRID_COLS = 3'd2;
   localparam logic [2:0] CSR_GRID_ROWS = 3'd3;
   localparam logic [2:0] CSR_ITER_LIM  = 3'd4;
   localparam logic [2:0] CSR_STOP_RES  = 3'd5;
   localparam logic [2:0] CSR_RES_THR   = 3'd6;

   localparam logic [59:0] RES_MAX = {60{1'b1}};
   localparam logic [30:0] CHG_MAX = {31{1'b1}};

   typedef enum logic [4:0] {
      ST_IDLE, ST_READ_OUT, ST_RUN_INIT, ST_SCAN,
      ST_RD_C, ST_RD_E, ST_RD_W, ST_RD_N, ST_RD_S,
      ST_MUL_X, ST_MUL_Y, ST_SUM, ST_DIFF,
      ST_SQ_A, ST_SQ_B, ST_SQ_C, ST_ACC,
      ST_PASS_END, ST_RUN_OUT
   } state_type;

   typedef enum logic [1:0] {PH_RED, PH_BLACK, PH_RES} phase_type;

   typedef enum logic [2:0] {SEL_C, SEL_E, SEL_W, SEL_N, SEL_S} cell_sel_type;

   typedef enum logic [3:0] {
      DP_NOP, DP_CAP_OLD, DP_CAP_E, DP_CAP_EW, DP_CAP_N, DP_CAP_NS,
      DP_MUL_Y, DP_SUM, DP_DIFF, DP_SQ_A, DP_SQ_B, DP_SQ_C, DP_ACC
   } dp_op_type;

   typedef struct packed {
      dp_op_type    op;
      cell_sel_type sel;
      logic [6:0]   r;
      logic [6:0]   c;
      logic         host_load;
      logic         host_read;
      logic         write_t;
      logic         upd_peak;
      logic         clr_peak;
      logic         clr_res;
      logic         rsp_read;
      logic         rsp_run;
   } dp_cmd_type;

   typedef struct packed {
      logic [6:0]  rows;
      logic [6:0]  cols;
      logic [21:0] limit;
      logic        stop;
      logic        below;
   } dp_status_type;

endpackage

// ===== rtl/rbgs_ctrl.sv =====
// rbgs_ctrl: sequencer for host commands, sweeps, residual passes and iterations
`timescale 1ns / 1ps
module rbgs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             req_opcode,
   input  rbgs_pkg::dp_status_type status,
   output logic                   busy,
   output rbgs_pkg::dp_cmd_type   cmd,
   output logic [21:0]            iter_count
);
   import rbgs_pkg::*;

   state_type  state_ff, state_in;
   phase_type  phase_ff, phase_in;
   logic [6:0] r_ff, r_in, c_ff, c_in;
   logic [21:0] it_ff, it_in;
   logic       have_res_ff, have_res_in, final_ff, final_in;

   logic       in_pass, skip, col_wrap, more_iter;
   logic [6:0] r_adv, c_adv;

   always_comb begin
      in_pass  = ({1'b0, r_ff} + 8'd1 < {1'b0, status.rows})
              && ({1'b0, c_ff} + 8'd1 < {1'b0, status.cols});
      skip     = ((phase_ff == PH_RED) && (r_ff[0] ^ c_ff[0]))
              || ((phase_ff == PH_BLACK) && !(r_ff[0] ^ c_ff[0]));
      col_wrap = ({1'b0, c_ff} + 8'd2 >= {1'b0, status.cols});
      r_adv    = col_wrap ? r_ff + 7'd1 : r_ff;
      c_adv    = col_wrap ? 7'd1 : c_ff + 7'd1;
      more_iter = it_ff < status.limit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         phase_ff    <= PH_RED;
         r_ff        <= 7'd1;
         c_ff        <= 7'd1;
         it_ff       <= '0;
         have_res_ff <= 1'b0;
         final_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         r_ff        <= r_in;
         c_ff        <= c_in;
         it_ff       <= it_in;
         have_res_ff <= have_res_in;
         final_ff    <= final_in;
      end
   end

   // next state
   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      r_in        = r_ff;
      c_in        = c_ff;
      it_in       = it_ff;
      have_res_in = have_res_ff;
      final_in    = final_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_opcode)
                  OP_RUN: begin
                     state_in    = ST_RUN_INIT;
                     it_in       = '0;
                     have_res_in = 1'b0;
                     final_in    = 1'b0;
                  end
                  OP_READ: state_in = ST_READ_OUT;
                  default: ;
               endcase
            end
         end
         ST_READ_OUT: state_in = ST_IDLE;
         ST_RUN_INIT: begin
            if (more_iter) begin
               state_in = ST_SCAN;
               phase_in = PH_RED;
               r_in     = 7'd1;
               c_in     = 7'd1;
            end else if (have_res_ff) begin
               state_in = ST_RUN_OUT;
            end else begin
               state_in = ST_SCAN;
               phase_in = PH_RES;
               final_in = 1'b1;
               r_in     = 7'd1;
               c_in     = 7'd1;
            end
         end
         ST_SCAN: begin
            if (!in_pass) begin
               state_in = ST_PASS_END;
            end else if (skip) begin
               r_in = r_adv;
               c_in = c_adv;
            end else begin
               state_in = ST_RD_C;
            end
         end
         ST_RD_C:  state_in = ST_RD_E;
         ST_RD_E:  state_in = ST_RD_W;
         ST_RD_W:  state_in = ST_RD_N;
         ST_RD_N:  state_in = ST_RD_S;
         ST_RD_S:  state_in = ST_MUL_X;
         ST_MUL_X: state_in = ST_MUL_Y;
         ST_MUL_Y: state_in = ST_SUM;
         ST_SUM:   state_in = ST_DIFF;
         ST_DIFF: begin
            if (phase_ff == PH_RES) begin
               state_in = ST_SQ_A;
            end else begin
               state_in = ST_SCAN;
               r_in     = r_adv;
               c_in     = c_adv;
            end
         end
         ST_SQ_A: state_in = ST_SQ_B;
         ST_SQ_B: state_in = ST_SQ_C;
         ST_SQ_C: state_in = ST_ACC;
         ST_ACC: begin
            state_in = ST_SCAN;
            r_in     = r_adv;
            c_in     = c_adv;
         end
         ST_PASS_END: begin
            case (phase_ff)
               PH_RED: begin
                  state_in = ST_SCAN;
                  phase_in = PH_BLACK;
                  r_in     = 7'd1;
                  c_in     = 7'd1;
               end
               PH_BLACK: begin
                  it_in = it_ff + 22'd1;
                  if (status.stop) begin
                     state_in    = ST_SCAN;
                     phase_in    = PH_RES;
                     have_res_in = 1'b1;
                     r_in        = 7'd1;
                     c_in        = 7'd1;
                  end else begin
                     state_in = ST_RUN_INIT;
                  end
               end
               PH_RES: begin
                  if (final_ff || status.below) state_in = ST_RUN_OUT;
                  else state_in = ST_RUN_INIT;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_RUN_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd           = '0;
      cmd.op        = DP_NOP;
      cmd.sel       = SEL_C;
      cmd.r         = r_ff;
      cmd.c         = c_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.host_load = start && (req_opcode == OP_LOAD);
            cmd.host_read = start && (req_opcode == OP_READ);
            cmd.clr_peak  = start && (req_opcode == OP_RUN);
         end
         ST_READ_OUT: cmd.rsp_read = 1'b1;
         ST_RUN_INIT: begin
            cmd.clr_peak = more_iter;
            cmd.clr_res  = !more_iter && !have_res_ff;
         end
         ST_RD_C:  cmd.sel = SEL_C;
         ST_RD_E: begin
            cmd.sel = SEL_E;
            cmd.op  = DP_CAP_OLD;
         end
         ST_RD_W: begin
            cmd.sel = SEL_W;
            cmd.op  = DP_CAP_E;
         end
         ST_RD_N: begin
            cmd.sel = SEL_N;
            cmd.op  = DP_CAP_EW;
         end
         ST_RD_S: begin
            cmd.sel = SEL_S;
            cmd.op  = DP_CAP_N;
         end
         ST_MUL_X: cmd.op = DP_CAP_NS;
         ST_MUL_Y: cmd.op = DP_MUL_Y;
         ST_SUM:   cmd.op = DP_SUM;
         ST_DIFF: begin
            cmd.op       = DP_DIFF;
            cmd.write_t  = (phase_ff != PH_RES);
            cmd.upd_peak = (phase_ff != PH_RES);
         end
         ST_SQ_A: cmd.op = DP_SQ_A;
         ST_SQ_B: cmd.op = DP_SQ_B;
         ST_SQ_C: cmd.op = DP_SQ_C;
         ST_ACC:  cmd.op = DP_ACC;
         ST_PASS_END: cmd.clr_res = (phase_ff == PH_BLACK) && status.stop;
         ST_RUN_OUT:  cmd.rsp_run = 1'b1;
         default: ;
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign iter_count = it_ff;

endmodule

// ===== rtl/rbgs_datapath.sv =====
// rbgs_datapath: grid memory, registers, stencil arithmetic and statistics
`timescale 1ns / 1ps
module rbgs_datapath #(
   parameter int GRID_SIDE = rbgs_pkg::GRID_SIDE_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [5:0]              req_row,
   input  logic [5:0]              req_col,
   input  logic signed [31:0]      req_value,
   input  logic                    csr_write_en,
   input  logic [2:0]              csr_index,
   input  logic [59:0]             csr_data,
   input  rbgs_pkg::dp_cmd_type    cmd,
   output rbgs_pkg::dp_status_type status,
   output logic signed [31:0]      rsp_read_value,
   output logic [30:0]             rsp_max_change,
   output logic [59:0]             rsp_residual,
   output logic                    rsp_converged
);
   import rbgs_pkg::*;

   localparam int CELLS = GRID_SIDE * GRID_SIDE;
   localparam int AW    = $clog2(CELLS);

   logic [15:0] weight_x_ff, weight_y_ff;
   logic [6:0]  grid_cols_ff, grid_rows_ff;
   logic [21:0] iter_lim_ff;
   logic        stop_res_ff;
   logic [59:0] res_thr_ff;

   logic [31:0] mem [CELLS];
   logic [31:0] rdata_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          wr_en;
   logic [31:0]   wr_data;
   logic          in_grid, in_grid_ff;
   int            base, host_base, sel_addr;

   logic signed [31:0] old_ff, e_ff, n_ff, t_ff;
   logic signed [32:0] ew_ff, ns_ff;
   logic signed [49:0] p1_ff, p2_ff;
   logic [31:0]        d_ff;
   logic [48:0]        sq_ff;
   logic [30:0]        peak_ff;
   logic [59:0]        res_ff;

   logic signed [50:0] acc;
   logic signed [34:0] shifted;
   logic signed [31:0] t_sat;
   logic signed [32:0] diff;
   logic [31:0]        d_abs;
   logic [30:0]        chg;
   logic [60:0]        res_sum;
   logic signed [34:0] val_hi, val_lo;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_x_ff  <= 16'd16384;
         weight_y_ff  <= 16'd16384;
         grid_cols_ff <= 7'd64;
         grid_rows_ff <= 7'd64;
         iter_lim_ff  <= 22'd100000;
         stop_res_ff  <= 1'b0;
         res_thr_ff   <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_WEIGHT_X:  weight_x_ff  <= csr_data[15:0];
            CSR_WEIGHT_Y:  weight_y_ff  <= csr_data[15:0];
            CSR_GRID_COLS: grid_cols_ff <= csr_data[6:0];
            CSR_GRID_ROWS: grid_rows_ff <= csr_data[6:0];
            CSR_ITER_LIM:  iter_lim_ff  <= csr_data[21:0];
            CSR_STOP_RES:  stop_res_ff  <= csr_data[0];
            CSR_RES_THR:   res_thr_ff   <= csr_data[59:0];
            default: ;
         endcase
      end
   end

   // addressing
   always_comb begin
      in_grid   = (int'(req_row) < GRID_SIDE) && (int'(req_col) < GRID_SIDE);
      host_base = int'(req_row) * GRID_SIDE + int'(req_col);
      base      = int'(cmd.r) * GRID_SIDE + int'(cmd.c);
      case (cmd.sel)
         SEL_C:   sel_addr = base;
         SEL_E:   sel_addr = base + 1;
         SEL_W:   sel_addr = base - 1;
         SEL_N:   sel_addr = base - GRID_SIDE;
         SEL_S:   sel_addr = base + GRID_SIDE;
         default: sel_addr = base;
      endcase
      rd_addr = cmd.host_read ? AW'(host_base) : AW'(sel_addr);
      wr_en   = (cmd.host_load && in_grid) || cmd.write_t;
      wr_addr = cmd.host_load ? AW'(host_base) : AW'(base);
      wr_data = cmd.host_load ? req_value : t_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rdata_ff <= mem[rd_addr];
   end

   // stencil arithmetic
   always_comb begin
      val_hi  = 35'sd2147483647;
      val_lo  = -35'sd2147483648;
      acc     = 51'(p1_ff) + 51'(p2_ff) + 51'sd32768;
      shifted = 35'(acc >>> 16);
      if (shifted > val_hi) t_sat = 32'(val_hi);
      else if (shifted < val_lo) t_sat = 32'(val_lo);
      else t_sat = 32'(shifted);
      diff    = 33'(t_ff) - 33'(old_ff);
      d_abs   = diff[32] ? 32'(-diff) : 32'(diff);
      chg     = d_abs[31] ? CHG_MAX : d_abs[30:0];
      res_sum = {1'b0, res_ff} + 61'(sq_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.host_read) in_grid_ff <= in_grid;
      case (cmd.op)
         DP_CAP_OLD: old_ff <= rdata_ff;
         DP_CAP_E:   e_ff   <= rdata_ff;
         DP_CAP_EW:  ew_ff  <= 33'(e_ff) + 33'($signed(rdata_ff));
         DP_CAP_N:   n_ff   <= rdata_ff;
         DP_CAP_NS: begin
            ns_ff <= 33'(n_ff) + 33'($signed(rdata_ff));
            p1_ff <= 50'($signed({1'b0, weight_x_ff}) * ew_ff);
         end
         DP_MUL_Y: p2_ff <= 50'($signed({1'b0, weight_y_ff}) * ns_ff);
         DP_SUM:   t_ff  <= t_sat;
         DP_DIFF:  d_ff  <= d_abs;
         DP_SQ_A:  sq_ff <= {1'b0, 32'(d_ff[31:16]) * 32'(d_ff[31:16]), 16'd0};
         DP_SQ_B:  sq_ff <= sq_ff + 49'({32'(d_ff[31:16]) * 32'(d_ff[15:0]), 1'b0});
         DP_SQ_C:  sq_ff <= sq_ff + 49'((32'(d_ff[15:0]) * 32'(d_ff[15:0])) >> 16);
         default: ;
      endcase
   end

   // statistics
   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= '0;
         res_ff  <= '0;
      end else begin
         if (cmd.clr_peak) peak_ff <= '0;
         else if (cmd.upd_peak && chg > peak_ff) peak_ff <= chg;
         if (cmd.clr_res) res_ff <= '0;
         else if (cmd.op == DP_ACC) res_ff <= res_sum[60] ? RES_MAX : res_sum[59:0];
      end
   end

   always_comb begin
      status.rows  = (int'(grid_rows_ff) > GRID_SIDE) ? 7'(GRID_SIDE) : grid_rows_ff;
      status.cols  = (int'(grid_cols_ff) > GRID_SIDE) ? 7'(GRID_SIDE) : grid_cols_ff;
      status.limit = iter_lim_ff;
      status.stop  = stop_res_ff;
      status.below = res_ff < res_thr_ff;
   end

   assign rsp_read_value = (cmd.rsp_read && in_grid_ff) ? rdata_ff : '0;
   assign rsp_max_change = cmd.rsp_run ? peak_ff : '0;
   assign rsp_residual   = cmd.rsp_run ? res_ff : '0;
   assign rsp_converged  = cmd.rsp_run && status.below;

endmodule

// ===== rtl/red_black_gauss_seidel_solver.sv =====
// red_black_gauss_seidel_solver: top level of the 2d laplace red-black gauss-seidel solver
`timescale 1ns / 1ps
// A word is accepted when start is high and busy is low. A load word writes one Q16.16
// cell and returns nothing; a read word raises busy and returns its cell in the cycle
// right after it is taken. A run word holds busy for the whole solve: each red or black
// sweep updates every interior cell of its color one at a time and steps over the cells
// of the other color, and a residual pass visits every interior cell, the pace of both
// set by the single read port of the grid memory and the shared stencil datapath.
// Results appear on the rsp_ ports for exactly one cycle with rsp_strobe high and cannot
// be held off, so capture them then. Configuration writes are taken at any time but belong
// only to idle periods.
module red_black_gauss_seidel_solver #(
   parameter int GRID_SIDE = rbgs_pkg::GRID_SIDE_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // command words
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [5:0]         req_row,
   input  logic [5:0]         req_col,
   input  logic signed [31:0] req_value,
   // result words
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_read_value,
   output logic [21:0]        rsp_iterations_done,
   output logic [30:0]        rsp_max_change,
   output logic [59:0]        rsp_residual,
   output logic               rsp_converged,
   // register writes
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [59:0]        csr_data
);
   import rbgs_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [21:0]   iter_count;

   // sequencer: host commands, sweep order, iteration and stop decisions
   rbgs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .status     (status),
      .busy       (busy),
      .cmd        (cmd),
      .iter_count (iter_count)
   );

   // grid memory, stencil arithmetic, change peak and residual sum
   rbgs_datapath #(
      .GRID_SIDE (GRID_SIDE)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_value      (req_value),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .cmd            (cmd),
      .status         (status),
      .rsp_read_value (rsp_read_value),
      .rsp_max_change (rsp_max_change),
      .rsp_residual   (rsp_residual),
      .rsp_converged  (rsp_converged)
   );

   // one strobe for both read and run results; iteration count only on run results
   assign rsp_strobe          = cmd.rsp_read || cmd.rsp_run;
   assign rsp_iterations_done = cmd.rsp_run ? iter_count : '0;

endmodule

// ===== bench/red_black_gauss_seidel_solver_tb.sv =====
// red_black_gauss_seidel_solver_tb: self-checking bench for the red-black gauss-seidel solver
`timescale 1ns / 1ps
module red_black_gauss_seidel_solver_tb;
   import rbgs_pkg::*;

   // opcode that the block ignores
   localparam logic [1:0] OP_NONE = 2'd3;
   localparam int SIDE = 64;

   typedef struct {
      logic [1:0]         op;
      logic [5:0]         row;
      logic [5:0]         col;
      logic signed [31:0] value;
   } cmd_word_type;

   typedef struct {
      logic signed [31:0] read_value;
      logic [21:0]        iterations_done;
      logic [30:0]        max_change;
      logic [59:0]        residual;
      logic               converged;
   } rsp_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_opcode = OP_LOAD;
   logic [5:0]         req_row = '0;
   logic [5:0]         req_col = '0;
   logic signed [31:0] req_value = '0;
   logic               rsp_strobe;
   logic signed [31:0] rsp_read_value;
   logic [21:0]        rsp_iterations_done;
   logic [30:0]        rsp_max_change;
   logic [59:0]        rsp_residual;
   logic               rsp_converged;
   logic               csr_write_en = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [59:0]        csr_data = '0;

   red_black_gauss_seidel_solver dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_row(req_row), .req_col(req_col), .req_value(req_value),
      .rsp_strobe(rsp_strobe), .rsp_read_value(rsp_read_value),
      .rsp_iterations_done(rsp_iterations_done), .rsp_max_change(rsp_max_change),
      .rsp_residual(rsp_residual), .rsp_converged(rsp_converged),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // shadow of the grid and the register file
   longint          grid_cells [SIDE*SIDE];
   longint          cfg_wx = 16384, cfg_wy = 16384;
   int              cfg_cols = 64, cfg_rows = 64;
   longint          cfg_limit = 100000;
   bit              cfg_stop = 1'b0;
   longint unsigned cfg_thr = 0;
   longint unsigned change_peak;

   cmd_word_type pending_words [$];
   rsp_word_type expected_words [$];
   cmd_word_type cur_word;
   int        send_idle = 36;
   int        error_count = 0;

   // stencil target of one interior cell, rounded and saturated to 32 bits
   function automatic longint cell_target(int r, int c);
      longint ew, ns, acc, t;
      ew = grid_cells[r*SIDE + c + 1] + grid_cells[r*SIDE + c - 1];
      ns = grid_cells[(r+1)*SIDE + c] + grid_cells[(r-1)*SIDE + c];
      acc = cfg_wx * ew + cfg_wy * ns;
      t = (acc + 32768) >>> 16;
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      return t;
   endfunction

   function automatic int eff_rows();
      return (cfg_rows > SIDE) ? SIDE : cfg_rows;
   endfunction

   function automatic int eff_cols();
      return (cfg_cols > SIDE) ? SIDE : cfg_cols;
   endfunction

   // one in-place sweep over the cells of one color
   function automatic void color_sweep(int color);
      int     rows, cols;
      longint t, d;
      rows = eff_rows();
      cols = eff_cols();
      if (rows < 3 || cols < 3) return;
      for (int r = 1; r + 1 < rows; r++)
         for (int c = 1; c + 1 < cols; c++) begin
            if (((r + c) & 1) != color) continue;
            t = cell_target(r, c);
            d = t - grid_cells[r*SIDE + c];
            if (d < 0) d = -d;
            if (d > 64'sd2147483647) d = 64'sd2147483647;
            if (d > longint'(change_peak)) change_peak = d;
            grid_cells[r*SIDE + c] = t;
         end
   endfunction

   // saturating sum of squared stencil error over the interior
   function automatic longint unsigned grid_residual();
      int              rows, cols;
      longint          d;
      longint unsigned dh, dl, sum;
      rows = eff_rows();
      cols = eff_cols();
      sum = 0;
      if (rows < 3 || cols < 3) return 0;
      for (int r = 1; r + 1 < rows; r++)
         for (int c = 1; c + 1 < cols; c++) begin
            d = cell_target(r, c) - grid_cells[r*SIDE + c];
            if (d < 0) d = -d;
            dh = d >> 16;
            dl = d & 64'hFFFF;
            sum += (dh * dh << 16) + 2 * dh * dl + ((dl * dl) >> 16);
            if (sum > RES_MAX) sum = RES_MAX;
         end
      return sum;
   endfunction

   // applies one accepted word and queues the result it causes
   function automatic void apply_word(cmd_word_type w);
      rsp_word_type    rw;
      longint unsigned res;
      longint          iters;
      bit              have_res;
      rw = '{default: '0};
      case (w.op)
         OP_LOAD: grid_cells[w.row*SIDE + w.col] = w.value;
         OP_READ: begin
            rw.read_value = grid_cells[w.row*SIDE + w.col];
            expected_words.push_back(rw);
         end
         OP_RUN: begin
            iters = 0;
            change_peak = 0;
            have_res = 1'b0;
            res = 0;
            for (longint it = 0; it < cfg_limit; it++) begin
               change_peak = 0;
               color_sweep(0);
               color_sweep(1);
               iters++;
               if (cfg_stop) begin
                  res = grid_residual();
                  have_res = 1'b1;
                  if (res < cfg_thr) break;
               end
            end
            if (!have_res) res = grid_residual();
            rw.iterations_done = iters;
            rw.max_change = change_peak;
            rw.residual = res;
            rw.converged = (res < cfg_thr);
            expected_words.push_back(rw);
         end
         default: ;
      endcase
   endfunction

   // driver: one word per accept, random gaps between words
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) apply_word(cur_word);
         if (!start || !busy) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
               cur_word = pending_words.pop_front();
               req_opcode <= cur_word.op;
               req_row <= cur_word.row;
               req_col <= cur_word.col;
               req_value <= cur_word.value;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: every strobed word against the oldest expectation
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_words.size() == 0) begin
            $display("%0t unexpected result word read_value %h", $time, rsp_read_value);
            error_count++;
         end else begin
            e = expected_words.pop_front();
            if (rsp_read_value !== e.read_value) begin
               $display("%0t read_value expected %h actual %h", $time, e.read_value,
                        rsp_read_value);
               error_count++;
            end
            if (rsp_iterations_done !== e.iterations_done) begin
               $display("%0t iterations_done expected %0d actual %0d", $time,
                        e.iterations_done, rsp_iterations_done);
               error_count++;
            end
            if (rsp_max_change !== e.max_change) begin
               $display("%0t max_change expected %h actual %h", $time, e.max_change,
                        rsp_max_change);
               error_count++;
            end
            if (rsp_residual !== e.residual) begin
               $display("%0t residual expected %h actual %h", $time, e.residual,
                        rsp_residual);
               error_count++;
            end
            if (rsp_converged !== e.converged) begin
               $display("%0t converged expected %b actual %b", $time, e.converged,
                        rsp_converged);
               error_count++;
            end
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [59:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      case (idx)
         CSR_WEIGHT_X:  cfg_wx = data[15:0];
         CSR_WEIGHT_Y:  cfg_wy = data[15:0];
         CSR_GRID_COLS: cfg_cols = data[6:0];
         CSR_GRID_ROWS: cfg_rows = data[6:0];
         CSR_ITER_LIM:  cfg_limit = data[21:0];
         CSR_STOP_RES:  cfg_stop = data[0];
         CSR_RES_THR:   cfg_thr = data;
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_config(int wx, int wy, int cols, int rows, int lim, bit stop,
                             logic [59:0] thr);
      write_reg(CSR_WEIGHT_X, wx);
      write_reg(CSR_WEIGHT_Y, wy);
      write_reg(CSR_GRID_COLS, cols);
      write_reg(CSR_GRID_ROWS, rows);
      write_reg(CSR_ITER_LIM, lim);
      write_reg(CSR_STOP_RES, stop);
      write_reg(CSR_RES_THR, thr);
   endtask

   task automatic push_word(logic [1:0] op, int r, int c, logic [31:0] v);
      cmd_word_type w;
      w.op = op;
      w.row = r;
      w.col = c;
      w.value = v;
      pending_words.push_back(w);
   endtask

   // waits until every word is taken and answered, then lets a load drain
   task automatic settle();
      while (pending_words.size() > 0 || start || expected_words.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      logic [59:0] thr;
      int          rows, cols;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // a small grid first, the default size would take far too long to solve
      set_config(16384, 16384, 5, 4, 3, 1'b0, 0);
      // the first three rows, the first three columns and the 10x10 corner get
      // written, which covers every cell that a read or a run below touches
      for (int r = 0; r < SIDE; r++)
         for (int c = 0; c < SIDE; c++)
            if (r < 3 || c < 3 || (r < 10 && c < 10))
               push_word(OP_LOAD, r, c, $urandom);
      push_word(OP_LOAD, 1, 1, 32'h7FFF_FFFF);
      push_word(OP_LOAD, 1, 2, 32'h8000_0000);
      push_word(OP_LOAD, 63, 63, 32'hFFFF_FFFF);
      push_word(OP_READ, 1, 1, 0);
      push_word(OP_READ, 1, 2, 0);
      push_word(OP_READ, 63, 63, 0);
      push_word(OP_READ, 0, 0, 0);
      push_word(OP_NONE, 2, 2, 32'h1234_5678);
      push_word(OP_RUN, 0, 0, 0);
      push_word(OP_READ, 1, 2, 0);
      settle();
      // zero iteration limit: residual of the grid as it stands
      write_reg(CSR_ITER_LIM, 0);
      push_word(OP_RUN, 0, 0, 0);
      settle();
      // no interior at all
      set_config(65535, 65535, 0, 2, 2, 1'b0, 1);
      push_word(OP_RUN, 0, 0, 0);
      settle();
      // oversize columns clamp to the full width, three rows keep it cheap
      set_config(65535, 0, 127, 3, 1, 1'b0, RES_MAX);
      push_word(OP_RUN, 0, 0, 0);
      push_word(OP_READ, 1, 40, 0);
      settle();
      set_config(0, 65535, 3, 64, 2, 1'b0, 0);
      push_word(OP_RUN, 0, 0, 0);
      settle();
      // stop mode with the widest limit must end after the first iteration
      set_config(20000, 12000, 6, 6, 4194303, 1'b1, RES_MAX);
      push_word(OP_RUN, 0, 0, 0);
      settle();

      // random phases: new settings each time, sender idling changes by thirds
      for (int p = 0; p < 15; p++) begin
         send_idle = (p < 5) ? 36 : (p < 10) ? 56 : 0;
         thr = ($urandom_range(3) == 0) ? {$urandom, $urandom} : $urandom_range(1 << 20);
         case ($urandom_range(3))
            0: set_config(0, 0, $urandom_range(2, 7), $urandom_range(2, 7),
                          $urandom_range(0, 4), $urandom_range(1), thr);
            1: set_config(65535, 65535, $urandom_range(3, 6), $urandom_range(3, 6),
                          $urandom_range(1, 3), $urandom_range(1), thr);
            default: set_config($urandom_range(65535), $urandom_range(65535),
                                $urandom_range(3, 8), $urandom_range(3, 8),
                                $urandom_range(1, 4), $urandom_range(1), thr);
         endcase
         rows = (cfg_rows > 10) ? 10 : cfg_rows;
         cols = (cfg_cols > 10) ? 10 : cfg_cols;
         for (int i = 0; i < 100; i++) begin
            case ($urandom_range(99)) inside
               [0:44]: push_word(OP_LOAD, $urandom_range(rows - 1), $urandom_range(cols - 1),
                                 $urandom);
               [45:54]: push_word(OP_LOAD, $urandom_range(63), $urandom_range(63), $urandom);
               // reads stay in the corner that is always loaded
               [55:84]: push_word(OP_READ, $urandom_range(9), $urandom_range(9), $urandom);
               [85:92]: push_word(OP_RUN, $urandom_range(63), $urandom_range(63), $urandom);
               default: push_word(OP_NONE, $urandom_range(63), $urandom_range(63), $urandom);
            endcase
         end
         settle();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // watchdog
   initial begin
      #50ms;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/rbgs_pkg.sv
rtl/rbgs_ctrl.sv
rtl/rbgs_datapath.sv
rtl/red_black_gauss_seidel_solver.sv
bench/red_black_gauss_seidel_solver_tb.sv
